>>> src/pcft_pkg.sv
// ----------------------------------------------------------------------------
// pcft_pkg
// Shared types and constants of the phase calibrated fine timestamp block.
// ----------------------------------------------------------------------------
package pcft_pkg;

	localparam int unsigned PCFT_SAMPLES = 16;

	localparam int CPU_W   = 10;
	localparam int CYC_W   = 32;
	localparam int US_W    = 64;
	localparam int NS_W    = 64;
	localparam int DRIFT_W = 18;
	localparam int PSUM_W  = 16;
	localparam int SSUM_W  = 17;
	localparam int MUL_B_W = 20;
	localparam int DIV_W   = 64;

	localparam logic [CPU_W-1:0]   CPU_RESET    = 10'd200;
	localparam logic [MUL_B_W-1:0] NS_PER_US    = 20'd1000;
	localparam logic [MUL_B_W-1:0] PPM_SCALE    = 20'd1000000;

	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	typedef struct packed {
		logic             is_req;
		logic [US_W-1:0]  us;
		logic [CYC_W-1:0] c0;
		logic [CYC_W-1:0] c1;
	} pcft_item_t;

	typedef struct packed {
		logic               start;
		logic [DIV_W-1:0]   a;
		logic [MUL_B_W-1:0] b;
	} pcft_mul_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] p;
	} pcft_mul_rsp_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} pcft_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] q;
		logic [DIV_W-1:0] r;
	} pcft_div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PHASE,
		ST_ACC,
		ST_MEAN,
		ST_SMOD,
		ST_SPAN,
		ST_IDEAL,
		ST_THRESH,
		ST_DMUL,
		ST_DDIV,
		ST_RMUL,
		ST_RMOD,
		ST_RSMUL,
		ST_RDIV,
		ST_OUT
	} pcft_state_t;

endpackage

>>> src/phase_calibrated_fine_timestamp.sv
// ----------------------------------------------------------------------------
// phase_calibrated_fine_timestamp
// Nanosecond timestamps from a coarse microsecond time and a cycle counter,
// with phase and drift calibration over a run of edge samples.
// ----------------------------------------------------------------------------
// Throughput: one item at a time; a two-entry input queue and a result
//   register let both sides stall on their own.
// Reset: clears calibration state and queues; cycles_per_us returns to 200.
module phase_calibrated_fine_timestamp #(
	parameter int unsigned SAMPLES = pcft_pkg::PCFT_SAMPLES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [9:0]         cfg_data,
	input  logic               push,
	output logic               full,
	input  logic               op,
	input  logic [63:0]        us_time,
	input  logic [31:0]        cycle_before,
	input  logic [31:0]        cycle_after,
	output logic               empty,
	input  logic               pop,
	output logic [63:0]        time_ns,
	output logic               interpolated,
	output logic               cal_done,
	output logic               cal_ok,
	output logic [9:0]         edge_phase,
	output logic signed [17:0] drift,
	output logic               is_calibrated
);
	import pcft_pkg::*;

	logic [CPU_W-1:0] cpu_q;
	logic             item_valid;
	logic             item_take;
	pcft_item_t       item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_q <= CPU_RESET;
		end else if (cfg_we) begin
			cpu_q <= cfg_data;
		end
	end

	pcft_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.op           (op),
		.us_time      (us_time),
		.cycle_before (cycle_before),
		.cycle_after  (cycle_after),
		.item_valid   (item_valid),
		.item         (item),
		.item_take    (item_take)
	);

	pcft_back #(.SAMPLES(SAMPLES)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cpu           (cpu_q),
		.item_valid    (item_valid),
		.item          (item),
		.item_take     (item_take),
		.empty         (empty),
		.pop           (pop),
		.time_ns       (time_ns),
		.interpolated  (interpolated),
		.cal_done      (cal_done),
		.cal_ok        (cal_ok),
		.edge_phase    (edge_phase),
		.drift         (drift),
		.is_calibrated (is_calibrated)
	);

endmodule

>>> src/pcft_front.sv
// ----------------------------------------------------------------------------
// pcft_front
// Input side: accepts items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module pcft_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     op,
	input  logic [63:0]              us_time,
	input  logic [31:0]              cycle_before,
	input  logic [31:0]              cycle_after,
	output logic                     item_valid,
	output pcft_pkg::pcft_item_t     item,
	input  logic                     item_take
);
	import pcft_pkg::*;

	pcft_item_t mem_q [2];
	pcft_item_t wr_item;
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       wr_en;

	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = mem_q[rp_q];
	assign wr_en      = push && !full;

	always_comb begin
		wr_item.is_req = (op == OP_REQUEST);
		wr_item.us     = us_time;
		wr_item.c0     = cycle_before;
		wr_item.c1     = cycle_after;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= !wp_q;
			end
			if (item_take) begin
				rp_q <= !rp_q;
			end
			case ({wr_en, item_take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> src/pcft_mul.sv
// ----------------------------------------------------------------------------
// pcft_mul
// Shift-add multiplier, one multiplier bit per cycle, product modulo 2^64.
// ----------------------------------------------------------------------------
module pcft_mul (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pcft_pkg::pcft_mul_req_t req,
	output pcft_pkg::pcft_mul_rsp_t rsp
);
	import pcft_pkg::*;

	logic [DIV_W-1:0]   a_q;
	logic [MUL_B_W-1:0] b_q;
	logic [DIV_W-1:0]   p_q;
	logic               busy_q;

	assign rsp.done = busy_q && (b_q == '0);
	assign rsp.p    = p_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			p_q <= '0;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				p_q <= p_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (rsp.done) begin
			busy_q <= 1'b0;
		end
	end

endmodule

>>> src/pcft_div.sv
// ----------------------------------------------------------------------------
// pcft_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcft_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pcft_pkg::pcft_div_req_t req,
	output pcft_pkg::pcft_div_rsp_t rsp
);
	import pcft_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fit;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fit   = (trial >= {1'b0, den_q});

	assign rsp.done = busy_q && (cnt_q == '0);
	assign rsp.q    = quo_q;
	assign rsp.r    = rem_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= fit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_W);
		end else if (rsp.done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> src/pcft_back.sv
// ----------------------------------------------------------------------------
// pcft_back
// Execution side: calibration accumulation, run finish and interpolation,
// sequenced over a shared multiplier and divider, with a result register.
// ----------------------------------------------------------------------------
module pcft_back #(
	parameter int unsigned SAMPLES = pcft_pkg::PCFT_SAMPLES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [9:0]           cpu,
	input  logic                 item_valid,
	input  pcft_pkg::pcft_item_t item,
	output logic                 item_take,
	output logic                 empty,
	input  logic                 pop,
	output logic [63:0]          time_ns,
	output logic                 interpolated,
	output logic                 cal_done,
	output logic                 cal_ok,
	output logic [9:0]           edge_phase,
	output logic signed [17:0]   drift,
	output logic                 is_calibrated
);
	import pcft_pkg::*;

	localparam int CNT_W   = $clog2(SAMPLES + 1);
	localparam int MEAN_SH = SSUM_W + $clog2(SAMPLES);
	localparam int PROD_W  = MEAN_SH + SSUM_W;
	localparam longint unsigned MEAN_RCP =
		((64'd1 << MEAN_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);

	pcft_state_t   state_q, state_d;
	pcft_mul_req_t mreq;
	pcft_mul_rsp_t mrsp;
	pcft_div_req_t dreq;
	pcft_div_rsp_t drsp;

	pcft_item_t               it_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CPU_W-1:0]         pmin_q, pmax_q, ph_q, mean_q, phase_q;
	logic [PSUM_W-1:0]        psum_q;
	logic signed [SSUM_W-1:0] ssum_q;
	logic [31:0]              fus_q, fcyc_q;
	logic [DRIFT_W-1:0]       drift_q;
	logic                     cal_q;
	logic [DIV_W-1:0]         ideal_q, tns_q;
	logic                     dneg_q, vneg_q, interp_q, done_q, ok_q;
	logic                     ov_q;

	logic                     last;
	logic                     wide;
	logic                     span_fwd;
	logic [DIV_W-1:0]         actual, diff64, dmag, dmag10;
	logic                     ok_c;
	logic [SSUM_W-1:0]        ssum_mag;
	logic [SSUM_W-1:0]        mean_src;
	logic [PROD_W-1:0]        mean_prod;
	logic [SSUM_W-1:0]        mean_quo;
	logic signed [SSUM_W-1:0] sm;
	logic signed [SSUM_W:0]   v;
	logic [SSUM_W:0]          v_mag;
	logic signed [SSUM_W-1:0] sh;
	logic [31:0]              dcyc, mid, rval;
	logic                     use_interp;
	logic [CPU_W-1:0]         mod_r;
	logic [DRIFT_W-1:0]       dq;

	pcft_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));
	pcft_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign last     = ({1'b0, cnt_q} + 1'b1) >= (CNT_W + 1)'(SAMPLES);
	assign wide     = ((pmax_q - pmin_q) > (cpu >> 1)) && (cpu != '0);
	assign span_fwd = it_q.us[31:0] > fus_q;
	assign actual   = {32'b0, it_q.c0 - fcyc_q};
	assign diff64   = actual - ideal_q;
	assign dmag     = diff64[DIV_W-1] ? (~diff64 + 1'b1) : diff64;
	// pass when the span error is within a tenth of the ideal span
	assign dmag10   = (dmag << 3) + (dmag << 1);
	assign ok_c     = (dmag10 <= ideal_q) && (ideal_q != '0);
	assign ssum_mag = ssum_q[SSUM_W-1] ? SSUM_W'(-ssum_q) : SSUM_W'(ssum_q);
	// divide by the run length through a reciprocal multiplication
	assign mean_src  = wide ? ssum_mag : {1'b0, psum_q};
	assign mean_prod = PROD_W'(mean_src) * PROD_W'(MEAN_RCP);
	assign mean_quo  = mean_prod[MEAN_SH +: SSUM_W];
	assign sm       = ssum_q[SSUM_W-1] ? -$signed(mean_quo) : $signed(mean_quo);
	assign v        = {sm[SSUM_W-1], sm} + $signed({8'b0, cpu});
	assign v_mag    = v[SSUM_W] ? (SSUM_W + 1)'(-v) : (SSUM_W + 1)'(v);
	assign sh       = (ph_q > (cpu >> 1)) ? $signed({7'b0, ph_q} - {7'b0, cpu})
	                                      : $signed({7'b0, ph_q});
	assign dcyc       = it_q.c1 - it_q.c0;
	assign mid        = it_q.c0 + (dcyc >> 1);
	assign rval       = mid - {22'b0, phase_q} + {22'b0, cpu};
	assign use_interp = cal_q && (cpu != '0) && (dcyc < {22'b0, cpu});
	assign mod_r      = vneg_q ? CPU_W'(~drsp.r + 1'b1) : drsp.r[CPU_W-1:0];
	assign dq         = dneg_q ? DRIFT_W'(~drsp.q + 1'b1) : drsp.q[DRIFT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		item_take = 1'b0;
		mreq      = '0;
		dreq      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_take = 1'b1;
					if (item.is_req) begin
						mreq.start = 1'b1;
						mreq.a     = item.us;
						mreq.b     = NS_PER_US;
						state_d    = ST_RMUL;
					end else if (cpu != '0) begin
						dreq.start = 1'b1;
						dreq.num   = {32'b0, item.c0};
						dreq.den   = {54'b0, cpu};
						state_d    = ST_PHASE;
					end else begin
						state_d = ST_ACC;
					end
				end
			end
			ST_PHASE: begin
				if (drsp.done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				state_d = last ? ST_MEAN : ST_OUT;
			end
			ST_MEAN: begin
				if (wide) begin
					dreq.start = 1'b1;
					dreq.num   = {46'b0, v_mag};
					dreq.den   = {54'b0, cpu};
					state_d    = ST_SMOD;
				end else begin
					state_d = ST_SPAN;
				end
			end
			ST_SMOD: begin
				if (drsp.done) begin
					state_d = ST_SPAN;
				end
			end
			ST_SPAN: begin
				if (span_fwd) begin
					mreq.start = 1'b1;
					mreq.a     = {32'b0, it_q.us[31:0] - fus_q};
					mreq.b     = {10'b0, cpu};
					state_d    = ST_IDEAL;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_IDEAL: begin
				if (mrsp.done) begin
					state_d = ST_THRESH;
				end
			end
			ST_THRESH: begin
				if (ok_c) begin
					mreq.start = 1'b1;
					mreq.a     = dmag;
					mreq.b     = PPM_SCALE;
					state_d    = ST_DMUL;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DMUL: begin
				if (mrsp.done) begin
					dreq.start = 1'b1;
					dreq.num   = mrsp.p;
					dreq.den   = ideal_q;
					state_d    = ST_DDIV;
				end
			end
			ST_DDIV: begin
				if (drsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_RMUL: begin
				if (mrsp.done) begin
					if (use_interp) begin
						dreq.start = 1'b1;
						dreq.num   = {32'b0, rval};
						dreq.den   = {54'b0, cpu};
						state_d    = ST_RMOD;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_RMOD: begin
				if (drsp.done) begin
					mreq.start = 1'b1;
					mreq.a     = {54'b0, drsp.r[CPU_W-1:0]};
					mreq.b     = NS_PER_US;
					state_d    = ST_RSMUL;
				end
			end
			ST_RSMUL: begin
				if (mrsp.done) begin
					dreq.start = 1'b1;
					dreq.num   = mrsp.p;
					dreq.den   = {54'b0, cpu};
					state_d    = ST_RDIV;
				end
			end
			ST_RDIV: begin
				if (drsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!ov_q || pop) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q     <= '0;
			cnt_q    <= '0;
			pmin_q   <= '0;
			pmax_q   <= '0;
			ph_q     <= '0;
			mean_q   <= '0;
			phase_q  <= '0;
			psum_q   <= '0;
			ssum_q   <= '0;
			fus_q    <= '0;
			fcyc_q   <= '0;
			drift_q  <= '0;
			cal_q    <= 1'b0;
			ideal_q  <= '0;
			tns_q    <= '0;
			dneg_q   <= 1'b0;
			vneg_q   <= 1'b0;
			interp_q <= 1'b0;
			done_q   <= 1'b0;
			ok_q     <= 1'b0;
			ov_q     <= 1'b0;
			time_ns       <= '0;
			interpolated  <= 1'b0;
			cal_done      <= 1'b0;
			cal_ok        <= 1'b0;
			edge_phase    <= '0;
			drift         <= '0;
			is_calibrated <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!ov_q || pop)) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						it_q     <= item;
						ph_q     <= '0;
						tns_q    <= '0;
						interp_q <= 1'b0;
						done_q   <= 1'b0;
						ok_q     <= 1'b0;
					end
				end
				ST_PHASE: begin
					if (drsp.done) begin
						ph_q <= drsp.r[CPU_W-1:0];
					end
				end
				ST_ACC: begin
					if (cnt_q == '0) begin
						fus_q  <= it_q.us[31:0];
						fcyc_q <= it_q.c0;
						pmin_q <= ph_q;
						pmax_q <= ph_q;
						psum_q <= {6'b0, ph_q};
						ssum_q <= sh;
					end else begin
						if (ph_q < pmin_q) begin
							pmin_q <= ph_q;
						end
						if (ph_q > pmax_q) begin
							pmax_q <= ph_q;
						end
						psum_q <= psum_q + {6'b0, ph_q};
						ssum_q <= ssum_q + sh;
					end
					if (last) begin
						cnt_q  <= '0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MEAN: begin
					if (wide) begin
						vneg_q <= v[SSUM_W];
					end else begin
						mean_q <= mean_quo[CPU_W-1:0];
					end
				end
				ST_SMOD: begin
					if (drsp.done) begin
						mean_q <= mod_r;
					end
				end
				ST_SPAN: begin
					if (!span_fwd) begin
						phase_q <= mean_q;
						cal_q   <= 1'b1;
						ok_q    <= 1'b1;
					end
				end
				ST_IDEAL: begin
					if (mrsp.done) begin
						ideal_q <= mrsp.p;
					end
				end
				ST_THRESH: begin
					dneg_q <= diff64[DIV_W-1];
					if (!ok_c) begin
						phase_q <= '0;
						drift_q <= '0;
					end
				end
				ST_DDIV: begin
					if (drsp.done) begin
						drift_q <= dq;
						phase_q <= mean_q;
						cal_q   <= 1'b1;
						ok_q    <= 1'b1;
					end
				end
				ST_RMUL: begin
					if (mrsp.done) begin
						tns_q <= mrsp.p;
					end
				end
				ST_RDIV: begin
					if (drsp.done) begin
						tns_q    <= tns_q + drsp.q;
						interp_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (!ov_q || pop) begin
						time_ns       <= tns_q;
						interpolated  <= interp_q;
						cal_done      <= done_q;
						cal_ok        <= ok_q;
						edge_phase    <= phase_q;
						drift         <= $signed(drift_q);
						is_calibrated <= cal_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign empty = !ov_q;

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq.start && dreq.start))
		else $error("multiplier and divider started together");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(SAMPLES))
		else $error("sample count out of range");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !pop) |=> ov_q)
		else $error("result dropped without transfer");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && (!ov_q || pop)) |=> (ov_q && state_q == ST_IDLE))
		else $error("result not loaded");

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the phase calibrated fine timestamp block against a cycle-free
// predictor: calibration runs with drift, jitter and phase wrap, timestamp
// requests near and far, under several idle/stall mixes and clock rates.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pcft_pkg::*;

	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [63:0] ns;
		logic        interp;
		logic        done;
		logic        ok;
		logic [9:0]  phase;
		logic [17:0] drift;
		logic        cal;
	} stamp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [9:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic op = OP_SAMPLE;
	logic [63:0] us_time = '0;
	logic [31:0] cycle_before = '0;
	logic [31:0] cycle_after = '0;
	logic empty;
	logic pop = 1'b0;
	logic [63:0] time_ns;
	logic interpolated, cal_done, cal_ok, is_calibrated;
	logic [9:0] edge_phase;
	logic signed [17:0] drift;

	pcft_item_t pending_items[$];
	stamp_t expected_stamps[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	longint cycles = 0;

	// predictor state
	logic [9:0]  cpu_cfg = CPU_RESET;
	int unsigned edge_count = 0;
	int unsigned ph_min = 0, ph_max = 0, ph_sum = 0;
	int          ph_ssum = 0;
	logic [31:0] first_us = '0, first_cyc = '0;
	int unsigned cal_phase = 0;
	int          cal_drift = 0;
	bit          calibrated = 0;

	phase_calibrated_fine_timestamp dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.push(push), .full(full), .op(op), .us_time(us_time),
		.cycle_before(cycle_before), .cycle_after(cycle_after),
		.empty(empty), .pop(pop), .time_ns(time_ns), .interpolated(interpolated),
		.cal_done(cal_done), .cal_ok(cal_ok), .edge_phase(edge_phase),
		.drift(drift), .is_calibrated(is_calibrated)
	);

	always #2 clk = ~clk;

	function automatic bit close_calibration(logic [31:0] us_last, logic [31:0] cyc_last);
		int unsigned cpu;
		int sm;
		longint unsigned ideal, actual, thresh;
		longint diff;
		cpu = cpu_cfg;
		if (ph_max - ph_min > cpu / 2 && cpu != 0) begin
			sm = ph_ssum / int'(PCFT_SAMPLES);
			cal_phase = (sm + int'(cpu)) % int'(cpu);
		end else begin
			cal_phase = ph_sum / PCFT_SAMPLES;
		end
		cal_phase &= 32'h3ff;
		if (us_last > first_us) begin
			ideal = longint'(us_last - first_us) * cpu;
			actual = longint'(cyc_last - first_cyc);
			thresh = ideal / 10;
			if (actual >= ideal - thresh && actual <= ideal + thresh && ideal > 0) begin
				diff = longint'(actual) - longint'(ideal);
				cal_drift = int'(diff * 1000000 / longint'(ideal));
			end else begin
				cal_phase = 0;
				cal_drift = 0;
				return 0;
			end
		end
		calibrated = 1;
		return 1;
	endfunction

	function automatic stamp_t compute_stamp(pcft_item_t it);
		stamp_t s;
		int unsigned cpu, ph;
		int sh;
		logic [31:0] d, mid, sub;
		s = '0;
		cpu = cpu_cfg;
		if (it.is_req == OP_SAMPLE) begin
			ph = (cpu == 0) ? 0 : it.c0 % cpu;
			sh = (ph > cpu / 2) ? int'(ph) - int'(cpu) : int'(ph);
			if (edge_count == 0) begin
				first_us = it.us[31:0];
				first_cyc = it.c0;
				ph_min = ph;
				ph_max = ph;
				ph_sum = ph;
				ph_ssum = sh;
			end else begin
				if (ph < ph_min) ph_min = ph;
				if (ph > ph_max) ph_max = ph;
				ph_sum = (ph_sum + ph) & 32'hffff;
				ph_ssum += sh;
			end
			edge_count++;
			if (edge_count >= PCFT_SAMPLES) begin
				edge_count = 0;
				s.done = 1;
				s.ok = close_calibration(it.us[31:0], it.c0);
			end
		end else begin
			d = it.c1 - it.c0;
			s.ns = it.us * 64'd1000;
			if (calibrated && cpu != 0 && d < cpu) begin
				mid = it.c0 + (d >> 1);
				sub = (mid - cal_phase + cpu) % cpu;
				s.ns += 64'((sub * 1000) / cpu);
				s.interp = 1;
			end
		end
		s.phase = cal_phase[9:0];
		s.drift = cal_drift[17:0];
		s.cal = calibrated;
		return s;
	endfunction

	// driver
	always @(posedge clk) begin
		pcft_item_t it;
		if (push && !full) begin
			it.is_req = op;
			it.us = us_time;
			it.c0 = cycle_before;
			it.c1 = cycle_after;
			expected_stamps.push_back(compute_stamp(it));
		end
		if (!push || !full) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				it = pending_items.pop_front();
				push <= 1'b1;
				op <= it.is_req;
				us_time <= it.us;
				cycle_before <= it.c0;
				cycle_after <= it.c1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		stamp_t got, want;
		if (!empty && pop) begin
			got = {time_ns, interpolated, cal_done, cal_ok, edge_phase, drift, is_calibrated};
			if (expected_stamps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: %p", got);
			end else begin
				want = expected_stamps.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", want, got);
				end
			end
		end
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic add_request(logic [63:0] us, logic [31:0] c0, logic [31:0] c1);
		pending_items.push_back('{OP_REQUEST, us, c0, c1});
	endtask

	task automatic add_sample(logic [63:0] us, logic [31:0] c);
		pending_items.push_back('{OP_SAMPLE, us, c, {$urandom}});
	endtask

	task automatic add_near_request();
		logic [31:0] c0;
		c0 = $urandom;
		if ($urandom_range(9) == 0)
			add_request({$urandom, $urandom}, c0, $urandom);
		else
			add_request({$urandom, $urandom}, c0, c0 + $urandom_range(0, int'(cpu_cfg) + 2));
	endtask

	task automatic add_run(int n);
		logic [63:0] us0;
		logic [31:0] c0;
		int cpu, step, err, jit, j;
		cpu = cpu_cfg;
		us0 = {$urandom, $urandom};
		step = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 3);
		err = $urandom_range(0, cpu / 4) - cpu / 8;
		jit = $urandom_range(0, cpu / 3 + 1);
		c0 = $urandom_range(1) ? $urandom : 32'(cpu * $urandom_range(0, 1000));
		for (int i = 0; i < n; i++) begin
			j = $urandom_range(0, 2 * jit) - jit;
			add_sample(us0 + 64'(i * step), c0 + 32'(i * step * (cpu + err) + j));
			if ($urandom_range(9) < 3)
				add_near_request();
		end
	endtask

	task automatic write_cpu(logic [9:0] v);
		wait (pending_items.size() == 0 && !push && expected_stamps.size() == 0);
		repeat (400) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cpu_cfg = v;
	endtask

	initial begin
		logic [9:0] cpus[8];
		int r, target;
		cpus = '{10'd200, 10'd1, 10'd1023, 10'd0, 10'd200, 10'd7, 10'd1023, 10'd200};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// uncalibrated requests and field extremes
		add_request('1, 32'h0, 32'hffffffff);
		add_request('0, 32'hffffffff, 32'hffffffff);
		add_request({$urandom, $urandom}, 32'h10, 32'h20);
		add_sample('1, 32'hffffffff);
		add_sample('0, 32'h0);
		add_run(14);
		// reads too far apart, then near reads
		add_request('1, 32'h5, 32'h5 + 32'd200);
		add_request('1, 32'hfffffff0, 32'h10);
		add_request('1, 32'hffffffff, 32'h0);

		for (int p = 0; p < 8; p++) begin
			write_cpu(p == 4 ? 10'($urandom_range(2, 1022)) : cpus[p]);
			send_idle_pct = (p % 4 == 1) ? 87 : (p % 4 == 3) ? 17 : 0;
			recv_stall_pct = (p % 4 == 2) ? 87 : (p % 4 == 3) ? 17 : 0;
			target = pending_items.size() + 150;
			while (pending_items.size() < target) begin
				r = $urandom_range(9);
				if (r < 6) add_run(PCFT_SAMPLES);
				else if (r < 8) add_near_request();
				else if (r == 8) add_sample({$urandom, $urandom}, $urandom);
				else add_run($urandom_range(1, PCFT_SAMPLES - 1));
			end
			if (p == 5) begin
				wait (pending_items.size() == 0 && expected_stamps.size() == 0);
				add_run(PCFT_SAMPLES);
			end
		end

		wait (pending_items.size() == 0 && !push && expected_stamps.size() == 0);
		repeat (400) @(posedge clk);
		if (mismatches == 0 && expected_stamps.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
